FILE: hdl/voxel_face_cull_mesher_unit_defines.svh
// assertion macros for the voxel face cull mesher
// used by voxel_face_cull_mesher_unit; no other dependencies
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define VFCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VFCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VFCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VFCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/vfcm_pkg.sv
// shared types, constants and the face corner table of the voxel mesher
// no dependencies
package vfcm_pkg;

    localparam int EDGE_LEN_DEF = 16;
    localparam int COORD_W      = 4;
    localparam int VERT_W       = 5;
    localparam int TYPE_W       = 8;
    localparam int NUM_FACES    = 6;
    localparam int VTX_PER_FACE = 6;
    localparam int STORE_ADDR_W_DEF = 3 * $clog2(EDGE_LEN_DEF);

    // function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MESH  = 1'b1;

    // face codes, in scan order
    localparam logic [2:0] FACE_NX = 3'd0;
    localparam logic [2:0] FACE_PX = 3'd1;
    localparam logic [2:0] FACE_NY = 3'd2;
    localparam logic [2:0] FACE_PY = 3'd3;
    localparam logic [2:0] FACE_NZ = 3'd4;
    localparam logic [2:0] FACE_PZ = 3'd5;

    typedef struct packed {
        logic              func;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COORD_W-1:0] z_pos;
        logic [TYPE_W-1:0]  voxel_type;
    } in_word_t;

    typedef struct packed {
        logic [VERT_W-1:0] vert_x;
        logic [VERT_W-1:0] vert_y;
        logic [VERT_W-1:0] vert_z;
        logic [TYPE_W-1:0] vert_type;
        logic [1:0]        normal_axis;
        logic              normal_negative;
        logic              no_face;
        logic              last;
    } out_word_t;

    // corner offsets per face and vertex, bit 0 dx, bit 1 dy, bit 2 dz
    localparam logic [2:0] CORNER_TAB [NUM_FACES][VTX_PER_FACE] = '{
        '{3'b000, 3'b100, 3'b010, 3'b010, 3'b100, 3'b110},
        '{3'b001, 3'b011, 3'b101, 3'b011, 3'b111, 3'b101},
        '{3'b000, 3'b001, 3'b100, 3'b001, 3'b101, 3'b100},
        '{3'b010, 3'b110, 3'b011, 3'b011, 3'b110, 3'b111},
        '{3'b000, 3'b010, 3'b001, 3'b010, 3'b011, 3'b001},
        '{3'b100, 3'b101, 3'b110, 3'b110, 3'b101, 3'b111}
    };

endpackage

FILE: hdl/vfcm_store.sv
// voxel type store: one write port, one registered read port, clear sweep after reset
// depends on vfcm_pkg
module vfcm_store
    import vfcm_pkg::*;
#(
    parameter int ADDR_W = STORE_ADDR_W_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [TYPE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TYPE_W-1:0] rd_data,
    output logic              busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [TYPE_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_busy_reg;
    logic [TYPE_W-1:0] rd_data_reg;

    // clear sweep, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // array write and registered read
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

FILE: hdl/voxel_face_cull_mesher_unit.sv
// Voxel face cull mesher. A write word (func 0) stores a type code and is taken with no
// result. A mesh word (func 1) reads the voxel and its six neighbors through the store's
// single read port, one entry per cycle (7 reads, then a drain state for the read
// latency), then sends one vertex word per cycle while the output does not stall, for
// each visible face, 6 per face, up to 36, or a single no-face word; a mesh request
// occupies the block until its last word is sent, one request at a time. After reset the
// store is swept to empty, one entry per cycle over all 2^(3*ceil(log2(EDGE_LEN))) entries
// (4096 at the default EDGE_LEN of 16), and s_ready stays low until the sweep is done.
// depends on vfcm_pkg, vfcm_store and voxel_face_cull_mesher_unit_defines.svh
`include "voxel_face_cull_mesher_unit_defines.svh"

module voxel_face_cull_mesher_unit
    import vfcm_pkg::*;
#(
    parameter int EDGE_LEN = EDGE_LEN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CW     = $clog2(EDGE_LEN);
    localparam int ADDR_W = 3 * CW;
    localparam int XW     = (CW > COORD_W) ? CW : COORD_W;
    localparam logic [XW-1:0] TOP_C = XW'(EDGE_LEN - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DRAIN, ST_EMIT} state_t;

    state_t            state_reg;
    logic [XW-1:0]     cx_reg, cy_reg, cz_reg;
    logic [2:0]        rd_idx_reg;
    logic              cap_valid_reg;
    logic [2:0]        cap_idx_reg;
    logic [TYPE_W-1:0] vt_reg;
    logic [NUM_FACES-1:0] vis_reg;
    logic [2:0]        vtx_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic              store_busy;
    logic [TYPE_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic              in_accept;
    logic              in_inside;
    logic [NUM_FACES-1:0] at_edge;
    logic [NUM_FACES-1:0] active;
    logic [NUM_FACES-1:0] remain;
    logic [2:0]        cur_face;
    logic [2:0]        corner;
    logic              out_free;
    logic              emit_fire;
    out_word_t         emit_word;

    function automatic logic [ADDR_W-1:0] pack_addr(logic [XW-1:0] x, logic [XW-1:0] y,
                                                    logic [XW-1:0] z);
        return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    // input side
    assign s_ready   = (state_reg == ST_IDLE) && !store_busy;
    assign in_accept = s_valid && s_ready;
    assign in_inside = (int'(s_data.x_pos) < EDGE_LEN) && (int'(s_data.y_pos) < EDGE_LEN) &&
                       (int'(s_data.z_pos) < EDGE_LEN);
    assign wr_en     = in_accept && (s_data.func == FUNC_WRITE) && in_inside;
    assign wr_addr   = pack_addr(XW'(s_data.x_pos), XW'(s_data.y_pos), XW'(s_data.z_pos));

    // chunk boundary per face
    assign at_edge = {cz_reg == TOP_C, cz_reg == '0, cy_reg == TOP_C, cy_reg == '0,
                      cx_reg == TOP_C, cx_reg == '0};

    // center and neighbor addresses
    always_comb begin
        case (rd_idx_reg)
            3'd1:    rd_addr = pack_addr(cx_reg - 1'b1, cy_reg, cz_reg);
            3'd2:    rd_addr = pack_addr(cx_reg + 1'b1, cy_reg, cz_reg);
            3'd3:    rd_addr = pack_addr(cx_reg, cy_reg - 1'b1, cz_reg);
            3'd4:    rd_addr = pack_addr(cx_reg, cy_reg + 1'b1, cz_reg);
            3'd5:    rd_addr = pack_addr(cx_reg, cy_reg, cz_reg - 1'b1);
            3'd6:    rd_addr = pack_addr(cx_reg, cy_reg, cz_reg + 1'b1);
            default: rd_addr = pack_addr(cx_reg, cy_reg, cz_reg);
        endcase
    end
    assign rd_en = (state_reg == ST_READ);

    // lowest visible face still to send
    assign active = (vt_reg != '0) ? vis_reg : '0;
    always_comb begin
        cur_face = FACE_NX;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (active[i]) begin
                cur_face = 3'(i);
            end
        end
    end
    always_comb begin
        remain = active;
        remain[cur_face] = 1'b0;
    end
    assign corner    = CORNER_TAB[cur_face][vtx_reg];
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    // next result word: vertex of the current face or the no-face word
    always_comb begin
        emit_word = '0;
        if (active == '0) begin
            emit_word.no_face = 1'b1;
            emit_word.last    = 1'b1;
        end else begin
            emit_word.vert_x          = {1'b0, cx_reg[COORD_W-1:0]} + VERT_W'(corner[0]);
            emit_word.vert_y          = {1'b0, cy_reg[COORD_W-1:0]} + VERT_W'(corner[1]);
            emit_word.vert_z          = {1'b0, cz_reg[COORD_W-1:0]} + VERT_W'(corner[2]);
            emit_word.vert_type       = vt_reg;
            emit_word.normal_axis     = cur_face[2:1];
            emit_word.normal_negative = !cur_face[0];
            emit_word.last            = (vtx_reg == 3'(VTX_PER_FACE - 1)) && (remain == '0);
        end
    end

    vfcm_store #(
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_data.voxel_type),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .busy   (store_busy)
    );

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            vtx_reg       <= '0;
        end else begin
            cap_valid_reg <= rd_en;
            cap_idx_reg   <= rd_idx_reg;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= emit_word;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // capture read data: center type, then neighbor emptiness
            if (cap_valid_reg) begin
                if (cap_idx_reg == 3'd0) begin
                    vt_reg <= rd_data;
                end else begin
                    vis_reg[cap_idx_reg - 3'd1] <= at_edge[cap_idx_reg - 3'd1] ||
                                                  (rd_data == '0);
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept && (s_data.func == FUNC_MESH)) begin
                        cx_reg     <= XW'(s_data.x_pos);
                        cy_reg     <= XW'(s_data.y_pos);
                        cz_reg     <= XW'(s_data.z_pos);
                        rd_idx_reg <= '0;
                        vtx_reg    <= '0;
                        if (in_inside) begin
                            state_reg <= ST_READ;
                        end else begin
                            vt_reg    <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_READ: begin
                    rd_idx_reg <= rd_idx_reg + 3'd1;
                    if (rd_idx_reg == 3'(NUM_FACES)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (active == '0) begin
                            state_reg <= ST_IDLE;
                        end else if (vtx_reg == 3'(VTX_PER_FACE - 1)) begin
                            vtx_reg           <= '0;
                            vis_reg[cur_face] <= 1'b0;
                            if (remain == '0) begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            vtx_reg <= vtx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `VFCM_ASSERT_IMP(a_clear_blocks_input, aclk, aresetn, store_busy, !s_ready,
                     "input taken during store clear")
    `VFCM_ASSERT_NXT(a_mesh_goes_busy, aclk, aresetn,
                     s_valid && s_ready && (s_data.func == FUNC_MESH), !s_ready,
                     "mesh word did not start the sequencer")
    `VFCM_ASSERT_IMP(a_no_face_clean, aclk, aresetn, m_valid && m_data.no_face,
                     m_data.last && (m_data.vert_type == '0) && (m_data.normal_axis == '0),
                     "no-face word not clean")
    `VFCM_ASSERT_IMP(a_face_filled, aclk, aresetn, m_valid && !m_data.no_face,
                     (m_data.vert_type != '0) && (m_data.normal_axis != 2'd3),
                     "vertex word from empty voxel or bad normal")

endmodule
